>>> sv/pmilj_pkg.sv
// Package with shared widths, field layout and carrier type for the pair set-up pipeline.
`timescale 1ns / 1ps
package pmilj_pkg;
    localparam int NREG    = 6;
    localparam int CW      = 21;
    localparam int PW      = 20;
    localparam int CNTW    = 14;
    localparam int RADW    = 42;
    localparam int ROOTW   = 21;
    localparam int REMW    = 24;
    localparam int NSQ     = 3;
    localparam int DATAW   = 224;
    localparam logic [21:0] DIST_MAX = 22'h3FFFFF;
    localparam logic [29:0] Q30_HALF = 30'h2000_0000;

    typedef struct packed {
        logic [62:0] draw;
        logic [62:0] dimg;
        logic        rd;
        logic        el;
        logic        frz;
        logic [15:0] half;
        logic [15:0] cs;
        logic [31:0] ep;
    } t_cr;
endpackage

>>> sv/pair_min_image_lj_mixing.sv
// Pair set-up: minimum-image displacement, distances, Lorentz-Berthelot mixing and flags.
// One atom pair per transaction; a new pair is taken every cycle while the result side
// keeps up. The pipeline has seven arithmetic stages (subtract, cell-count products,
// rounding, projection products, saturation, squares, sum), 21 stages of a bit-per-stage
// square root shared in three lanes, and the output register. A stall on the output
// freezes the whole pipeline. Cell registers are 64-bit APB words at byte address 8*i.
`timescale 1ns / 1ps
module pair_min_image_lj_mixing (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [5:0]                  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // pos_first, pos_second, same_molecule, eps_first, sig_first, eps_second, sig_second,
    // chg_first, chg_second, frz_first, frz_second
    input  logic [pmilj_pkg::DATAW-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // rd_excl, es_excl, pair_frozen, disp_raw, disp_image, dist_raw, dist_image,
    // mix_sigma, mix_eps, nbr_charge
    output logic [pmilj_pkg::DATAW-1:0] m_axis_tdata
);
    localparam int NV = 7 + pmilj_pkg::ROOTW + 1;

    logic [62:0]  r_cfg [pmilj_pkg::NREG];
    logic [2:0]   w_idx;
    logic         w_adv;
    logic [NV-1:0] r_v;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pmilj_pkg::NREG; i++) r_cfg[i] <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (32'(w_idx) < pmilj_pkg::NREG)) begin
            r_cfg[w_idx] <= pwdata[62:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (32'(w_idx) < pmilj_pkg::NREG) prdata = {1'b0, r_cfg[w_idx]};
    end

    assign w_adv         = !r_v[NV-1] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_v[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (w_adv) r_v <= {r_v[NV-2:0], s_axis_tvalid};
    end

    // stage 1: raw displacement, flags, sigma mix, epsilon product
    pmilj_pkg::t_cr n1_c, r1_c, r2_c, r3_c, r4_c, r5_c, r6_c, r7_c;
    logic signed [pmilj_pkg::CW-1:0] w_d [3];
    logic [15:0] w_ef, w_sf, w_es, w_ss, w_cf, w_cs;
    logic [16:0] w_ssum, w_half;

    always_comb begin
        w_ef   = s_axis_tdata[136:121];
        w_sf   = s_axis_tdata[152:137];
        w_es   = s_axis_tdata[168:153];
        w_ss   = s_axis_tdata[184:169];
        w_cf   = s_axis_tdata[200:185];
        w_cs   = s_axis_tdata[216:201];
        for (int p = 0; p < 3; p++) begin
            w_d[p] = pmilj_pkg::CW'($signed(s_axis_tdata[pmilj_pkg::PW*p +: pmilj_pkg::PW]))
                   - pmilj_pkg::CW'($signed(s_axis_tdata[60 + pmilj_pkg::PW*p +:
                                                          pmilj_pkg::PW]));
        end
        w_ssum = 17'(w_sf) + 17'(w_ss);
        w_half = {1'b0, w_ssum[16:1]} + 17'(w_ssum[0] & w_ssum[1]);
        n1_c       = '0;
        n1_c.draw  = {w_d[2], w_d[1], w_d[0]};
        if (s_axis_tdata[120]) begin
            n1_c.rd = 1'b1;
            n1_c.el = 1'b1;
        end else begin
            n1_c.rd = (w_ef == '0) || (w_sf == '0) || (w_es == '0) || (w_ss == '0);
            n1_c.el = (w_cf == '0) || (w_cs == '0);
        end
        n1_c.frz  = s_axis_tdata[217] & s_axis_tdata[218];
        n1_c.half = w_half[16] ? 16'hFFFF : w_half[15:0];
        n1_c.cs   = w_cs;
        n1_c.ep   = w_ef * w_es;
    end

    always_ff @(posedge i_clk) if (w_adv) r1_c <= n1_c;

    // stage 2: reciprocal products and raw squares
    logic signed [41:0] r2_pr [3][3];
    logic        [41:0] r2_sq [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_c <= r1_c;
            for (int p = 0; p < 3; p++) begin
                r2_sq[p] <= 42'($signed(r1_c.draw[21*p +: 21]) *
                                $signed(r1_c.draw[21*p +: 21]));
                for (int q = 0; q < 3; q++) begin
                    r2_pr[p][q] <= $signed(r_cfg[3+p][21*q +: 21]) *
                                   $signed(r1_c.draw[21*q +: 21]);
                end
            end
        end
    end

    // stage 3: cell counts rounded to nearest, ties to even
    logic signed [pmilj_pkg::CNTW-1:0] r3_cnt [3];
    logic        [41:0]                r3_rsq;
    logic signed [43:0]                w_s3 [3];
    logic signed [pmilj_pkg::CNTW-1:0] w_q3 [3];
    logic        [29:0]                w_f3 [3];

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            w_s3[p] = 44'(r2_pr[p][0]) + 44'(r2_pr[p][1]) + 44'(r2_pr[p][2]);
            w_q3[p] = w_s3[p][43:30];
            w_f3[p] = w_s3[p][29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_c   <= r2_c;
            r3_rsq <= r2_sq[0] + r2_sq[1] + r2_sq[2];
            for (int p = 0; p < 3; p++) begin
                if (w_f3[p] > pmilj_pkg::Q30_HALF ||
                    (w_f3[p] == pmilj_pkg::Q30_HALF && w_q3[p][0]))
                    r3_cnt[p] <= w_q3[p] + pmilj_pkg::CNTW'(1);
                else
                    r3_cnt[p] <= w_q3[p];
            end
        end
    end

    // stage 4: projection products
    logic signed [34:0] r4_bp [3][3];
    logic        [41:0] r4_rsq;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_c   <= r3_c;
            r4_rsq <= r3_rsq;
            for (int p = 0; p < 3; p++)
                for (int q = 0; q < 3; q++)
                    r4_bp[p][q] <= $signed(r_cfg[p][21*q +: 21]) * r3_cnt[q];
        end
    end

    // stage 5: subtract and saturate
    logic        [41:0] r5_rsq;
    logic signed [37:0] w_t5 [3];
    logic signed [20:0] w_di [3];
    pmilj_pkg::t_cr     w_c5;

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            w_t5[p] = 38'($signed(r4_c.draw[21*p +: 21]))
                    - (38'(r4_bp[p][0]) + 38'(r4_bp[p][1]) + 38'(r4_bp[p][2]));
            if (w_t5[p] > 38'sd1048575)       w_di[p] = 21'sd1048575;
            else if (w_t5[p] < -38'sd1048576) w_di[p] = -21'sd1048576;
            else                              w_di[p] = w_t5[p][20:0];
        end
        w_c5      = r4_c;
        w_c5.dimg = {w_di[2], w_di[1], w_di[0]};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_c   <= w_c5;
            r5_rsq <= r4_rsq;
        end
    end

    // stages 6 and 7: image squares and their sum
    logic [41:0] r6_isq [3];
    logic [41:0] r6_rsq, r7_rsq, r7_isum;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_c   <= r5_c;
            r6_rsq <= r5_rsq;
            for (int p = 0; p < 3; p++)
                r6_isq[p] <= 42'($signed(r5_c.dimg[21*p +: 21]) *
                                 $signed(r5_c.dimg[21*p +: 21]));
            r7_c    <= r6_c;
            r7_rsq  <= r6_rsq;
            r7_isum <= r6_isq[0] + r6_isq[1] + r6_isq[2];
        end
    end

    // square roots, one result bit per stage; lanes: raw, image, epsilon
    logic [pmilj_pkg::RADW-1:0]  r_rad  [pmilj_pkg::ROOTW][pmilj_pkg::NSQ];
    logic [pmilj_pkg::ROOTW-1:0] r_root [pmilj_pkg::ROOTW][pmilj_pkg::NSQ];
    logic [pmilj_pkg::REMW-1:0]  r_rem  [pmilj_pkg::ROOTW][pmilj_pkg::NSQ];
    pmilj_pkg::t_cr              r_sc   [pmilj_pkg::ROOTW];

    genvar k, l;
    generate
        for (k = 0; k < pmilj_pkg::ROOTW; k++) begin : g_sq
            logic [pmilj_pkg::RADW-1:0]  w_rin  [pmilj_pkg::NSQ];
            logic [pmilj_pkg::ROOTW-1:0] w_oin  [pmilj_pkg::NSQ];
            logic [pmilj_pkg::REMW-1:0]  w_min  [pmilj_pkg::NSQ];
            pmilj_pkg::t_cr              w_cin;
            if (k == 0) begin : g_first
                always_comb begin
                    w_rin[0] = r7_rsq;
                    w_rin[1] = r7_isum;
                    w_rin[2] = pmilj_pkg::RADW'(r7_c.ep);
                    for (int j = 0; j < pmilj_pkg::NSQ; j++) begin
                        w_oin[j] = '0;
                        w_min[j] = '0;
                    end
                    w_cin = r7_c;
                end
            end else begin : g_next
                always_comb begin
                    for (int j = 0; j < pmilj_pkg::NSQ; j++) begin
                        w_rin[j] = r_rad[k-1][j];
                        w_oin[j] = r_root[k-1][j];
                        w_min[j] = r_rem[k-1][j];
                    end
                    w_cin = r_sc[k-1];
                end
            end
            for (l = 0; l < pmilj_pkg::NSQ; l++) begin : g_ln
                logic [pmilj_pkg::REMW-1:0] w_sh, w_tr;
                assign w_sh = {w_min[l][pmilj_pkg::REMW-3:0],
                               w_rin[l][pmilj_pkg::RADW-1-2*k -: 2]};
                assign w_tr = {1'b0, w_oin[l], 2'b01};
                always_ff @(posedge i_clk) begin
                    if (w_adv) begin
                        r_rad[k][l] <= w_rin[l];
                        if (w_sh >= w_tr) begin
                            r_rem[k][l]  <= w_sh - w_tr;
                            r_root[k][l] <= {w_oin[l][pmilj_pkg::ROOTW-2:0], 1'b1};
                        end else begin
                            r_rem[k][l]  <= w_sh;
                            r_root[k][l] <= {w_oin[l][pmilj_pkg::ROOTW-2:0], 1'b0};
                        end
                    end
                end
            end
            always_ff @(posedge i_clk) if (w_adv) r_sc[k] <= w_cin;
        end
    endgenerate

    // output register: round the roots to nearest and saturate
    localparam int LS = pmilj_pkg::ROOTW - 1;
    logic [21:0] w_rt [pmilj_pkg::NSQ];
    logic [21:0] w_draw, w_dimg;
    logic [15:0] w_meps;
    pmilj_pkg::t_cr w_oc;
    logic [pmilj_pkg::DATAW-1:0] r_out;

    always_comb begin
        for (int j = 0; j < pmilj_pkg::NSQ; j++)
            w_rt[j] = 22'(r_root[LS][j]) +
                      22'(r_rem[LS][j] > pmilj_pkg::REMW'(r_root[LS][j]));
        w_draw = (w_rt[0] > pmilj_pkg::DIST_MAX) ? pmilj_pkg::DIST_MAX : w_rt[0];
        w_dimg = (w_rt[1] > pmilj_pkg::DIST_MAX) ? pmilj_pkg::DIST_MAX : w_rt[1];
        w_meps = (w_rt[2] > 22'h00FFFF) ? 16'hFFFF : w_rt[2][15:0];
        w_oc   = r_sc[LS];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= {3'b000, w_oc.cs, w_meps, w_oc.half, w_dimg, w_draw,
                      w_oc.dimg, w_oc.draw, w_oc.frz, w_oc.el, w_oc.rd};
        end
    end

    assign m_axis_tdata = r_out;
endmodule

>>> sv/pmilj_checker.sv
// Port checker for the pair set-up block, bound to the top level.
`timescale 1ns / 1ps
module pmilj_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [pmilj_pkg::DATAW-1:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[223:221] == 3'b000)
        else $error("padding bits set");
endmodule

bind pair_min_image_lj_mixing pmilj_checker u_pmilj_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/pair_min_image_lj_mixing_chk.sv
// Checker for the pair set-up block: predicts each result and compares it with the output stream.
`timescale 1ns / 1ps
package pair_tb_pkg;
    typedef struct packed {
        logic        frz_second;
        logic        frz_first;
        logic [15:0] chg_second;
        logic [15:0] chg_first;
        logic [15:0] sig_second;
        logic [15:0] eps_second;
        logic [15:0] sig_first;
        logic [15:0] eps_first;
        logic        same_molecule;
        logic [59:0] pos_second;
        logic [59:0] pos_first;
    } pair_in_t;

    typedef struct packed {
        logic [15:0] nbr_charge;
        logic [15:0] mix_eps;
        logic [15:0] mix_sigma;
        logic [21:0] dist_image;
        logic [21:0] dist_raw;
        logic [62:0] disp_image;
        logic [62:0] disp_raw;
        logic        pair_frozen;
        logic        es_excl;
        logic        rd_excl;
    } pair_res_t;
endpackage

module pair_min_image_lj_mixing_chk
    import pair_tb_pkg::*;
(
    input  logic         i_clk,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    input  logic         pready,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [223:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [223:0] m_axis_tdata,
    output int           o_errors,
    output int           o_pending
);
    logic [62:0] cell_regs [6];
    pair_res_t   expected_pairs [$];

    initial begin
        o_errors = 0;
        for (int i = 0; i < 6; i++) cell_regs[i] = '0;
    end

    assign o_pending = expected_pairs.size();

    function automatic longint coef(input int r, input int c);
        logic signed [20:0] v;
        v = cell_regs[r][21*c +: 21];
        return v;
    endfunction

    function automatic longint pos_comp(input logic [59:0] p, input int c);
        logic signed [19:0] v;
        v = p[20*c +: 20];
        return v;
    endfunction

    function automatic longint unsigned root_nearest(input longint unsigned n);
        longint unsigned r, x, b;
        r = 0;
        x = n;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (x > r) r++;
        return r;
    endfunction

    function automatic logic [21:0] length_of(input longint v [3]);
        longint unsigned sq, r;
        sq = 0;
        for (int p = 0; p < 3; p++) sq += longint'(v[p] * v[p]);
        r = root_nearest(sq);
        return (r > 64'h3FFFFF) ? 22'h3FFFFF : r[21:0];
    endfunction

    function automatic pair_res_t predict_pair(input pair_in_t a);
        pair_res_t   res;
        longint      d [3];
        longint      di [3];
        longint      n [3];
        longint      s;
        longint      rem;
        logic [16:0] ssum;
        logic [16:0] half;
        longint unsigned me;
        for (int p = 0; p < 3; p++) d[p] = pos_comp(a.pos_first, p) - pos_comp(a.pos_second, p);
        for (int p = 0; p < 3; p++) begin
            s = 0;
            for (int q = 0; q < 3; q++) s += coef(3 + p, q) * d[q];
            n[p] = s >>> 30;
            rem = s & 64'h3FFF_FFFF;
            if (rem > 64'h2000_0000 || (rem == 64'h2000_0000 && n[p][0])) n[p]++;
        end
        for (int p = 0; p < 3; p++) begin
            s = 0;
            for (int q = 0; q < 3; q++) s += coef(p, q) * n[q];
            s = d[p] - s;
            if (s > 1048575) s = 1048575;
            if (s < -1048576) s = -1048576;
            di[p] = s;
        end
        if (a.same_molecule) begin
            res.rd_excl = 1'b1;
            res.es_excl = 1'b1;
        end else begin
            res.rd_excl = (a.eps_first == 0 || a.sig_first == 0 ||
                           a.eps_second == 0 || a.sig_second == 0);
            res.es_excl = (a.chg_first == 0 || a.chg_second == 0);
        end
        res.pair_frozen = a.frz_first & a.frz_second;
        for (int p = 0; p < 3; p++) begin
            res.disp_raw[21*p +: 21]   = d[p][20:0];
            res.disp_image[21*p +: 21] = di[p][20:0];
        end
        res.dist_raw   = length_of(d);
        res.dist_image = length_of(di);
        ssum = {1'b0, a.sig_first} + {1'b0, a.sig_second};
        half = ssum >> 1;
        if (ssum[0] && half[0]) half++;
        res.mix_sigma = (half > 17'hFFFF) ? 16'hFFFF : half[15:0];
        me = root_nearest(longint'(a.eps_first) * longint'(a.eps_second));
        res.mix_eps = (me > 64'hFFFF) ? 16'hFFFF : me[15:0];
        res.nbr_charge = a.chg_second;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        pair_res_t e;
        pair_res_t r;
        if (psel && penable && pwrite && pready && paddr[5:3] < 6)
            cell_regs[paddr[5:3]] <= pwdata[62:0];
        if (s_axis_tvalid && s_axis_tready)
            expected_pairs.push_back(predict_pair(pair_in_t'(s_axis_tdata[218:0])));
        if (m_axis_tvalid && m_axis_tready) begin
            r = pair_res_t'(m_axis_tdata[220:0]);
            if (expected_pairs.size() == 0) begin
                $error("result transaction with no pair outstanding");
                o_errors++;
            end else begin
                e = expected_pairs.pop_front();
                check_field("rd_excl", e.rd_excl, r.rd_excl);
                check_field("es_excl", e.es_excl, r.es_excl);
                check_field("pair_frozen", e.pair_frozen, r.pair_frozen);
                check_field("disp_raw", e.disp_raw, r.disp_raw);
                check_field("disp_image", e.disp_image, r.disp_image);
                check_field("dist_raw", e.dist_raw, r.dist_raw);
                check_field("dist_image", e.dist_image, r.dist_image);
                check_field("mix_sigma", e.mix_sigma, r.mix_sigma);
                check_field("mix_eps", e.mix_eps, r.mix_eps);
                check_field("nbr_charge", e.nbr_charge, r.nbr_charge);
            end
        end
    end
endmodule

>>> dv/pair_min_image_lj_mixing_tb.sv
// Testbench top for the pair set-up block: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module pair_min_image_lj_mixing_tb;
    import pair_tb_pkg::*;

    localparam int PHASE_PAIRS = 165;

    logic         i_clk;
    logic         i_rst_n;
    logic         psel, penable, pwrite, pready;
    logic [5:0]   paddr;
    logic [63:0]  pwdata, prdata;
    logic         s_axis_tvalid, s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic         m_axis_tvalid, m_axis_tready;
    logic [223:0] m_axis_tdata;
    int           errors, pending;
    int           pairs_sent;

    pair_min_image_lj_mixing DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    pair_min_image_lj_mixing_chk u_chk (
        .i_clk(i_clk), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400000);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [62:0] pk3(input logic [20:0] c0, c1, c2);
        return {c2, c1, c0};
    endfunction

    function automatic logic [59:0] pos3(input logic [19:0] x, y, z);
        return {z, y, x};
    endfunction

    function automatic logic [19:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 20'($urandom);
            1: return 20'($signed($urandom_range(0, 80000)) - 40000);
            2: return 20'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
        endcase
    endfunction

    function automatic logic [15:0] rand_param();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pair_in_t rand_pair();
        pair_in_t a;
        a.pos_first     = pos3(rand_coord(), rand_coord(), rand_coord());
        a.pos_second    = pos3(rand_coord(), rand_coord(), rand_coord());
        a.same_molecule = ($urandom_range(0, 5) == 0);
        a.eps_first     = rand_param();
        a.sig_first     = rand_param();
        a.eps_second    = rand_param();
        a.sig_second    = rand_param();
        a.chg_first     = rand_param();
        a.chg_second    = rand_param();
        a.frz_first     = 1'($urandom);
        a.frz_second    = 1'($urandom);
        return a;
    endfunction

    function automatic pair_in_t make_pair(input logic [59:0] p1, p2, input logic same,
                                           input logic [15:0] e1, s1, e2, s2, c1, c2,
                                           input logic f1, f2);
        pair_in_t a;
        a.pos_first = p1;   a.pos_second = p2;   a.same_molecule = same;
        a.eps_first = e1;   a.sig_first = s1;    a.eps_second = e2;
        a.sig_second = s2;  a.chg_first = c1;    a.chg_second = c2;
        a.frz_first = f1;   a.frz_second = f2;
        return a;
    endfunction

    task automatic reg_write(input int idx, input logic [63:0] val);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = 6'(idx * 8); pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic load_cell(input logic [62:0] b0, b1, b2, r0, r1, r2);
        reg_write(0, b0); reg_write(1, b1); reg_write(2, b2);
        reg_write(3, r0); reg_write(4, r1); reg_write(5, r2);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (35) @(posedge i_clk);
    endtask

    task automatic send_pair(input pair_in_t a);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'b0, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pairs_sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {$urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom};
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random(input int count, input bit pause_mid);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            if (burst > left) burst = left;
            repeat (burst) send_pair(rand_pair());
            left -= burst;
            if (pause_mid && left < count / 2) begin
                pause_mid = 0;
                idle_gap(1);
                while (pending != 0) @(posedge i_clk);
            end
            idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
        end
        idle_gap(1);
    endtask

    // receiver: changing stall pattern, with one long hold-off to back the pipe up
    initial begin
        int mode;
        bit held;
        m_axis_tready = 1'b0;
        held = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (!held && pairs_sent >= 400) begin
                held = 1;
                m_axis_tready = 1'b0;
                repeat (300) @(negedge i_clk);
            end else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = ($urandom_range(0, 3) != 0);
                    default: m_axis_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        pairs_sent = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // 16 A orthorhombic cell: recip is an exact power of two, so ties are reachable
        load_cell(pk3(16384, 0, 0), pk3(0, 16384, 0), pk3(0, 0, 16384),
                  pk3(65536, 0, 0), pk3(0, 65536, 0), pk3(0, 0, 65536));
        send_pair(make_pair(pos3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF),
                            pos3(20'h80000, 20'h80000, 20'h80000), 0,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 1, 1));
        send_pair(make_pair(pos3(20'h80000, 20'h80000, 20'h80000),
                            pos3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF), 0,
                            1, 1, 1, 1, 16'hFFFF, 16'h0001, 0, 1));
        send_pair(make_pair(pos3(8192, 24576, 40960), pos3(0, 0, 0), 0,
                            100, 4096, 200, 4097, 4096, 4096, 1, 0));
        send_pair(make_pair(pos3(0, 0, 0), pos3(8192, 24576, 40960), 0,
                            100, 4097, 200, 4098, 4096, 4096, 0, 0));
        send_pair(make_pair(pos3(8191, 8193, 16384), pos3(0, 0, 0), 1,
                            0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(pos3(1000, 2000, 3000), pos3(1000, 2000, 3000), 0,
                            0, 4096, 64, 4096, 4096, 4096, 0, 0));
        send_pair(make_pair(pos3(5, 6, 7), pos3(1, 2, 3), 0,
                            64, 0, 64, 4096, 4096, 4096, 0, 0));
        send_pair(make_pair(pos3(5, 6, 7), pos3(1, 2, 3), 0,
                            64, 4096, 0, 4096, 4096, 4096, 0, 0));
        send_pair(make_pair(pos3(5, 6, 7), pos3(1, 2, 3), 0,
                            64, 4096, 64, 0, 4096, 4096, 0, 0));
        send_pair(make_pair(pos3(5, 6, 7), pos3(1, 2, 3), 0,
                            64, 4096, 64, 4096, 0, 4096, 0, 0));
        send_pair(make_pair(pos3(5, 6, 7), pos3(1, 2, 3), 0,
                            64, 4096, 64, 4096, 4096, 0, 0, 0));
        send_pair(make_pair(pos3(5, 6, 7), pos3(1, 2, 3), 1,
                            64, 4096, 64, 4096, 4096, 4096, 1, 1));
        send_pair(make_pair(pos3(20'hFE000, 0, 0), pos3(8192, 0, 0), 0,
                            16'hFFFF, 1, 1, 16'hFFFF, 16'h8000, 16'hFFFF, 0, 1));
        send_pair(make_pair(pos3(0, 0, 0), pos3(0, 0, 0), 0,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 1, 1));
        idle_gap(1);
        wait_drained();

        send_random(PHASE_PAIRS, 0);
        wait_drained();

        // zero cell, with the unused addresses poked as well
        load_cell('0, '0, '0, '0, '0, '0);
        reg_write(6, {64{1'b1}});
        reg_write(7, {64{1'b1}});
        send_random(PHASE_PAIRS, 1);
        wait_drained();

        load_cell(pk3(10240, 0, 0), pk3(0, 10240, 0), pk3(0, 0, 10240),
                  pk3(104858, 0, 0), pk3(0, 104858, 0), pk3(0, 0, 104858));
        send_random(PHASE_PAIRS, 0);
        wait_drained();

        // every coefficient -1, top bit of the bus set as well
        reg_write(0, {64{1'b1}}); reg_write(1, {64{1'b1}}); reg_write(2, {64{1'b1}});
        reg_write(3, {64{1'b1}}); reg_write(4, {64{1'b1}}); reg_write(5, {64{1'b1}});
        send_random(PHASE_PAIRS, 0);
        wait_drained();

        // largest basis against most negative reciprocal: image saturates
        load_cell(pk3(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF),
                  pk3(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF),
                  pk3(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF),
                  pk3(21'h100000, 21'h100000, 21'h100000),
                  pk3(21'h100000, 21'h100000, 21'h100000),
                  pk3(21'h100000, 21'h100000, 21'h100000));
        send_random(PHASE_PAIRS, 0);
        wait_drained();

        load_cell(63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                  63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                  63'({$urandom, $urandom}), 63'({$urandom, $urandom}));
        send_random(PHASE_PAIRS, 0);
        wait_drained();

        load_cell(pk3(14000, 21'($urandom_range(0, 4000)), 0),
                  pk3(21'($signed($urandom_range(0, 4000)) - 2000), 15000, 0),
                  pk3(21'($urandom_range(0, 3000)), 21'($urandom_range(0, 3000)), 17000),
                  pk3(75000, 21'($signed($urandom_range(0, 8000)) - 4000), 0),
                  pk3(0, 70000, 21'($urandom_range(0, 6000))),
                  pk3(21'($signed($urandom_range(0, 6000)) - 3000), 0, 61000));
        send_random(PHASE_PAIRS, 0);

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> files.f
sv/pmilj_pkg.sv
sv/pair_min_image_lj_mixing.sv
sv/pmilj_checker.sv
dv/pair_min_image_lj_mixing_chk.sv
dv/pair_min_image_lj_mixing_tb.sv
